/* src/ctc_pkg.sv */
// Shared types, constants and register codes for the color threshold centroid block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ctc_pkg;

   // Raster limits
   localparam int MAX_ROWS = 1024;
   localparam int MAX_COLS = 1024;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

   // Field and accumulator widths
   localparam int PIX_W   = 8;
   localparam int SUM_W   = 30;
   localparam int CNT_W   = 21;
   localparam int COORD_W = 10;
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0]   CNT_INIT  = CNT_W'(1);
   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

   // Divider: one quotient bit per step over the whole dividend
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   // Configuration register codes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLUE_LIMIT  = 2'd0,
      CSR_GREEN_LIMIT = 2'd1,
      CSR_RED_FLOOR   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_limit;
      logic [PIX_W-1:0] green_limit;
      logic [PIX_W-1:0] red_floor;
   } thresh_type;

   typedef struct packed {
      logic [SUM_W-1:0] row_sum;
      logic [SUM_W-1:0] col_sum;
      logic [CNT_W-1:0] hit_count;
   } frame_stat_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* src/ctc_if.sv */
// Channel interfaces of the color threshold centroid block: pixel, result and CSR write.
// Depends on ctc_pkg for field widths.
`default_nettype none

interface ctc_pixel_if import ctc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;
   logic             line_end;
   logic             frame_end;

   modport source (output valid, blue, green, red, line_end, frame_end, input ready);
   modport sink   (input valid, blue, green, red, line_end, frame_end, output ready);
endinterface

interface ctc_result_if import ctc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mask;
   logic               centroid_valid;
   logic [COORD_W-1:0] centroid_row;
   logic [COORD_W-1:0] centroid_col;

   modport source (output valid, mask, centroid_valid, centroid_row, centroid_col,
                   input ready);
   modport sink   (input valid, mask, centroid_valid, centroid_row, centroid_col,
                   output ready);
endinterface

interface ctc_csr_if import ctc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PIX_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/ctc_accum.sv */
// Pixel threshold test, raster coordinate counters and per-frame coordinate sums.
// Depends on ctc_pkg.
`default_nettype none

module ctc_accum import ctc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire thresh_type       thresh,
   input  wire logic [PIX_W-1:0] blue,
   input  wire logic [PIX_W-1:0] green,
   input  wire logic [PIX_W-1:0] red,
   input  wire logic             line_end,
   input  wire logic             frame_end,
   output logic                  fg,
   output frame_stat_type        stat_nxt
);

   logic [ROW_W-1:0] row_idx_ff, row_idx_in;
   logic [COL_W-1:0] col_idx_ff, col_idx_in;
   frame_stat_type   stat_ff, stat_in;
   logic [SUM_W:0]   row_add;
   logic [SUM_W:0]   col_add;

   // Foreground test
   assign fg = (red > thresh.red_floor) && (blue < thresh.blue_limit)
               && (green < thresh.green_limit);

   // Saturating sums including the current pixel
   always_comb begin
      row_add = {1'b0, stat_ff.row_sum} + (SUM_W + 1)'(row_idx_ff);
      col_add = {1'b0, stat_ff.col_sum} + (SUM_W + 1)'(col_idx_ff);
      stat_nxt = stat_ff;
      if (fg) begin
         stat_nxt.row_sum   = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
         stat_nxt.col_sum   = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
         stat_nxt.hit_count = (stat_ff.hit_count == CNT_MAX) ? CNT_MAX
                              : stat_ff.hit_count + CNT_W'(1);
      end
   end

   // Coordinate and sum update per beat
   always_comb begin
      row_idx_in = row_idx_ff;
      col_idx_in = col_idx_ff;
      stat_in    = stat_ff;
      if (accept) begin
         if (frame_end) begin
            row_idx_in        = '0;
            col_idx_in        = '0;
            stat_in.row_sum   = '0;
            stat_in.col_sum   = '0;
            stat_in.hit_count = CNT_INIT;
         end else begin
            stat_in = stat_nxt;
            if (line_end) begin
               col_idx_in = '0;
               if (row_idx_ff < ROW_LAST) begin
                  row_idx_in = row_idx_ff + ROW_W'(1);
               end
            end else if (col_idx_ff < COL_LAST) begin
               col_idx_in = col_idx_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_idx_ff        <= '0;
         col_idx_ff        <= '0;
         stat_ff.row_sum   <= '0;
         stat_ff.col_sum   <= '0;
         stat_ff.hit_count <= CNT_INIT;
      end else begin
         row_idx_ff <= row_idx_in;
         col_idx_ff <= col_idx_in;
         stat_ff    <= stat_in;
      end
   end

endmodule

`default_nettype wire

/* src/ctc_divider.sv */
// Shared restoring divider: one quotient bit per cycle, quotient saturated to a coordinate.
// Depends on ctc_pkg.
`default_nettype none

module ctc_divider import ctc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W+1:0]  trial;

   // Trial subtraction of the divisor from the shifted remainder
   assign trial = {1'b0, rem_ff, quo_ff[SUM_W-1]} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial[CNT_W+1]) begin
            rem_in = {rem_ff[CNT_W-2:0], quo_ff[SUM_W-1]};
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   // Result clamps at the largest coordinate
   assign rsp.done     = done_ff;
   assign rsp.quotient = (|quo_ff[SUM_W-1:COORD_W]) ? COORD_MAX : quo_ff[COORD_W-1:0];

endmodule

`default_nettype wire

/* src/color_threshold_centroid.sv */
// Top level of the color threshold centroid block: CSRs, sequencer and result register.
// Depends on ctc_pkg, ctc_if, ctc_accum and ctc_divider.
`default_nettype none

// Each pixel beat yields one result beat carrying its foreground mask bit. Ordinary
// pixels stream at one per clock while the result side keeps up. The pixel marked
// frame_end also carries the centroid (row and column sums divided by one plus the
// hit count, clamped to 1023); those two quotients come from a single shared
// restoring divider that produces one quotient bit per cycle, so that pixel's result
// beat appears only after both divisions, and no pixel is taken meanwhile. The user
// must write thresholds through the CSR channel only while the block is idle; the
// block itself does not enforce this. Thresholds reset to zero.
module color_threshold_centroid import ctc_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   ctc_pixel_if.sink    req,
   ctc_result_if.source rsp,
   ctc_csr_if.sink      csr
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DIV_ROW = 3'b010,
      ST_DIV_COL = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   thresh_type         thresh_ff, thresh_in;
   logic               req_beat;
   logic               fg;
   frame_stat_type     stat_nxt;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               mask_hold_ff, mask_hold_in;
   logic [SUM_W-1:0]   col_op_ff, col_op_in;
   logic [CNT_W-1:0]   cnt_op_ff, cnt_op_in;
   logic [COORD_W-1:0] row_q_ff, row_q_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_mask_ff, out_mask_in;
   logic               out_cvalid_ff, out_cvalid_in;
   logic [COORD_W-1:0] out_row_ff, out_row_in;
   logic [COORD_W-1:0] out_col_ff, out_col_in;

   // CSR writes
   assign csr.ready = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_BLUE_LIMIT:  thresh_in.blue_limit  = csr.data;
            CSR_GREEN_LIMIT: thresh_in.green_limit = csr.data;
            CSR_RED_FLOOR:   thresh_in.red_floor   = csr.data;
            default:         thresh_in = thresh_ff;
         endcase
      end
   end

   // Pixel side handshake
   assign req.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign req_beat  = req.valid && req.ready;

   ctc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_beat),
      .thresh    (thresh_ff),
      .blue      (req.blue),
      .green     (req.green),
      .red       (req.red),
      .line_end  (req.line_end),
      .frame_end (req.frame_end),
      .fg        (fg),
      .stat_nxt  (stat_nxt)
   );

   ctc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer: ordinary pixels go straight to the result register, frame end
   // runs the row division and then the column division on the shared unit
   always_comb begin
      state_in      = state_ff;
      mask_hold_in  = mask_hold_ff;
      col_op_in     = col_op_ff;
      cnt_op_in     = cnt_op_ff;
      row_q_in      = row_q_ff;
      div_req.start    = 1'b0;
      div_req.dividend = stat_nxt.row_sum;
      div_req.divisor  = stat_nxt.hit_count;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_mask_in   = out_mask_ff;
      out_cvalid_in = out_cvalid_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req.frame_end) begin
                  div_req.start = 1'b1;
                  mask_hold_in  = fg;
                  col_op_in     = stat_nxt.col_sum;
                  cnt_op_in     = stat_nxt.hit_count;
                  state_in      = ST_DIV_ROW;
               end else begin
                  out_valid_in  = 1'b1;
                  out_mask_in   = fg;
                  out_cvalid_in = 1'b0;
                  out_row_in    = '0;
                  out_col_in    = '0;
               end
            end
         end
         ST_DIV_ROW: begin
            div_req.dividend = col_op_ff;
            div_req.divisor  = cnt_op_ff;
            if (div_rsp.done) begin
               row_q_in      = div_rsp.quotient;
               div_req.start = 1'b1;
               state_in      = ST_DIV_COL;
            end
         end
         ST_DIV_COL: begin
            div_req.dividend = col_op_ff;
            div_req.divisor  = cnt_op_ff;
            if (div_rsp.done) begin
               out_valid_in  = 1'b1;
               out_mask_in   = mask_hold_ff;
               out_cvalid_in = 1'b1;
               out_row_in    = row_q_ff;
               out_col_in    = div_rsp.quotient;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         thresh_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         thresh_ff    <= thresh_in;
      end
      mask_hold_ff  <= mask_hold_in;
      col_op_ff     <= col_op_in;
      cnt_op_ff     <= cnt_op_in;
      row_q_ff      <= row_q_in;
      out_mask_ff   <= out_mask_in;
      out_cvalid_ff <= out_cvalid_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
   end

   // Result beat
   assign rsp.valid          = out_valid_ff;
   assign rsp.mask           = out_mask_ff;
   assign rsp.centroid_valid = out_cvalid_ff;
   assign rsp.centroid_row   = out_row_ff;
   assign rsp.centroid_col   = out_col_ff;

endmodule

`default_nettype wire
